// ===== rtl/core/esc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  // item field widths
  localparam int SECS_W  = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  // internal values between the split and the two back-end paths
  localparam int DAYS_W = 16;  // whole days since the epoch, at most 49710
  localparam int SOD_W  = 17;  // second of the day, below 86400

  // register stages of each part
  localparam int SPLIT_STAGES = 2;
  localparam int DATE_STAGES  = 7;
  localparam int TOD_STAGES   = 4;

endpackage

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Throughput: one item per cycle; the whole pipeline holds while the
// final result is stalled, so the rate is set by the output side alone.
// Reset: synchronous, active low; clears only the valid bits of the
// nine stages, payload registers are left as they are.
`timescale 1ns / 1ps
`default_nettype none

// Unix time to UTC calendar date and time of day.
//
// Stage map:
//   1-2  day split: seconds -> whole days and second of day
//   3-9  date path: era, day of era, year of era, day of year, month,
//        weekday (by (days + 4) mod 7, epoch was a Thursday)
//   3-6  time path: hour, minute, second; then delayed to stage 9
//
// Divides by 675, 3600, 60, 1460, 7, 365 and 153 are reciprocal multiplies
// with a register after each, exact over the operand range; powers of two
// are shifts and the century and era-end terms compares. The pipeline
// advances as one unit: any cycle the output item is not stalled, every
// stage moves forward, so an empty output slot never blocks the input.
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SECS_W-1:0]  in_epoch_seconds,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [YEAR_W-1:0]  out_year_value,
  output logic      [MONTH_W-1:0] out_month_index,
  output logic      [DAY_W-1:0]   out_day_of_month,
  output logic      [HOUR_W-1:0]  out_hour_value,
  output logic      [MIN_W-1:0]   out_minute_value,
  output logic      [SEC_W-1:0]   out_second_value,
  output logic      [WDAY_W-1:0]  out_weekday
);

  localparam int LATENCY = SPLIT_STAGES + DATE_STAGES;

  logic               en;
  logic [LATENCY-1:0] vld_r;
  logic [DAYS_W-1:0]  days;
  logic [SOD_W-1:0]   sod;

  // hold everything only when the output item is waiting and stalled
  assign en       = !(vld_r[LATENCY-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LATENCY-2:0], in_valid};
    end
  end

  esc_day_split u_split (
    .clk  (clk),
    .en   (en),
    .secs (in_epoch_seconds),
    .days (days),
    .sod  (sod)
  );

  esc_date u_date (
    .clk   (clk),
    .en    (en),
    .days  (days),
    .year  (out_year_value),
    .month (out_month_index),
    .mday  (out_day_of_month),
    .wday  (out_weekday)
  );

  esc_tod u_tod (
    .clk    (clk),
    .en     (en),
    .sod    (sod),
    .hour   (out_hour_value),
    .minute (out_minute_value),
    .second (out_second_value)
  );

  assign out_valid = vld_r[LATENCY-1];

`ifndef SYNTH
  // an accepted item must land in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted item missing from first stage");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_value < 5'd24 && out_minute_value < 6'd60
                   && out_second_value < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_index < 4'd12 && out_day_of_month != 5'd0
                   && out_weekday < 3'd7))
    else $error("date field out of range");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year_value >= 12'd1970 && out_year_value <= 12'd2106))
    else $error("year out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/esc_day_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Splits seconds into whole days and second of day.
// secs / 86400 = (secs >> 7) / 675, done as a reciprocal multiply
// (ceil(2^35 / 675), exact for any 25-bit operand).
module esc_day_split
  import esc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SECS_W-1:0] secs,
  output logic      [DAYS_W-1:0] days,
  output logic      [SOD_W-1:0]  sod
);

  localparam logic [25:0] RECIP_675 = 26'd50903317;
  localparam logic [24:0] DIV_675   = 25'd675;

  logic [SECS_W-1:0] secs1_r;
  logic [DAYS_W-1:0] days1_r;
  logic [DAYS_W-1:0] days1_nxt;
  logic [50:0]       prod;

  logic [DAYS_W-1:0] days2_r;
  logic [SOD_W-1:0]  sod2_r;
  logic [SOD_W-1:0]  sod2_nxt;
  logic [24:0]       rem;

  always_comb begin
    prod      = {26'd0, secs[SECS_W-1:7]} * {25'd0, RECIP_675};
    days1_nxt = prod[50:35];
  end

  always_comb begin
    rem      = secs1_r[SECS_W-1:7] - ({9'd0, days1_r} * DIV_675);
    sod2_nxt = {rem[9:0], secs1_r[6:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      secs1_r <= secs;
      days1_r <= days1_nxt;
      days2_r <= days1_r;
      sod2_r  <= sod2_nxt;
    end
  end

  assign days = days2_r;
  assign sod  = sod2_r;

endmodule

`default_nettype wire

// ===== rtl/core/esc_tod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hour, minute and second from the second of the day. Reciprocal
// multiplies are exact over the full operand range; the tail delay
// line lines the results up with the date path.
module esc_tod
  import esc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SOD_W-1:0]  sod,
  output logic      [HOUR_W-1:0] hour,
  output logic      [MIN_W-1:0]  minute,
  output logic      [SEC_W-1:0]  second
);

  localparam int LINE_DEPTH = DATE_STAGES - TOD_STAGES + 1;

  localparam logic [15:0] RECIP_3600 = 16'd37283;  // ceil(2^27 / 3600)
  localparam logic [12:0] RECIP_60   = 13'd4370;   // ceil(2^18 / 60)
  localparam logic [11:0] SECS_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_MIN   = 6'd60;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } hms_t;

  logic [SOD_W-1:0]  sod1_r;
  logic [HOUR_W-1:0] hour1_r;
  logic [HOUR_W-1:0] hour1_nxt;
  logic [32:0]       hprod;

  logic [HOUR_W-1:0] hour2_r;
  logic [11:0]       rsec2_r;
  logic [11:0]       rsec2_nxt;
  logic [SOD_W-1:0]  hsub;

  logic [HOUR_W-1:0] hour3_r;
  logic [11:0]       rsec3_r;
  logic [MIN_W-1:0]  min3_r;
  logic [MIN_W-1:0]  min3_nxt;
  logic [24:0]       mprod;

  logic [11:0]       ssub;
  hms_t              hms_nxt;
  hms_t              line_r [LINE_DEPTH];

  always_comb begin
    hprod     = {16'd0, sod} * {17'd0, RECIP_3600};
    hour1_nxt = hprod[31:27];
  end

  always_comb begin
    hsub      = sod1_r - ({12'd0, hour1_r} * {5'd0, SECS_HOUR});
    rsec2_nxt = hsub[11:0];
  end

  always_comb begin
    mprod    = {13'd0, rsec2_r} * {12'd0, RECIP_60};
    min3_nxt = mprod[23:18];
  end

  always_comb begin
    ssub           = rsec3_r - ({6'd0, min3_r} * {6'd0, SECS_MIN});
    hms_nxt.hour   = hour3_r;
    hms_nxt.minute = min3_r;
    hms_nxt.second = ssub[SEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sod1_r    <= sod;
      hour1_r   <= hour1_nxt;
      hour2_r   <= hour1_r;
      rsec2_r   <= rsec2_nxt;
      hour3_r   <= hour2_r;
      rsec3_r   <= rsec2_r;
      min3_r    <= min3_nxt;
      line_r[0] <= hms_nxt;
      for (int i = 1; i < LINE_DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign hour   = line_r[LINE_DEPTH-1].hour;
  assign minute = line_r[LINE_DEPTH-1].minute;
  assign second = line_r[LINE_DEPTH-1].second;

endmodule

`default_nettype wire

// ===== rtl/core/esc_date.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Civil date from day count, counted in 400-year eras that start on
// March 1st (era 4 opens 1600-03-01, era 5 opens 2000-03-01).
// Weekday is (days + 4) mod 7; the epoch fell on a Thursday.
module esc_date
  import esc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [DAYS_W-1:0]  days,
  output logic      [YEAR_W-1:0]  year,
  output logic      [MONTH_W-1:0] month,
  output logic      [DAY_W-1:0]   mday,
  output logic      [WDAY_W-1:0]  wday
);

  localparam logic [DAYS_W-1:0] ERA5_START = 16'd11017;  // days to 2000-03-01
  localparam logic [17:0] ERA4_BIAS    = 18'd135080;     // day of era on the epoch
  localparam logic [17:0] RECIP_1460   = 18'd183860;     // ceil(2^28 / 1460)
  localparam logic [16:0] RECIP_7      = 17'd74899;      // ceil(2^19 / 7)
  localparam logic [18:0] RECIP_365    = 19'd367720;     // ceil(2^27 / 365)
  localparam logic [12:0] RECIP_153    = 13'd6854;       // ceil(2^20 / 153)
  localparam logic [17:0] CENT_DAYS    = 18'd36524;
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
  localparam logic [YEAR_W-1:0] ERA4_YEAR = 12'd1600;
  localparam logic [YEAR_W-1:0] ERA5_YEAR = 12'd2000;

  // first day of each month, counted from March 1st
  function automatic logic [8:0] march_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // stage 1: era and day of era
  logic        era1_r, era1_nxt;
  logic [17:0] doe1_r, doe1_nxt;
  logic [15:0] wx1_r, wx1_nxt;

  // stage 2: doe / 1460, century count, weekday quotient
  logic        era2_r;
  logic [17:0] doe2_r;
  logic [15:0] wx2_r;
  logic [6:0]  q1460_2_r, q1460_nxt;
  logic [2:0]  cent2_r, cent_nxt;
  logic        last2_r, last_nxt;
  logic [13:0] q7_2_r, q7_nxt;
  logic [35:0] prod1460;
  logic [32:0] prod7;

  // stage 3: leap-corrected day count, weekday
  logic        era3_r;
  logic [17:0] doe3_r;
  logic [17:0] t3_r, t_nxt;
  logic [WDAY_W-1:0] wd3_r, wd_nxt;
  logic [15:0] wsub;

  // stage 4: year of era
  logic        era4_r;
  logic [17:0] doe4_r;
  logic [8:0]  yoe4_r, yoe_nxt;
  logic [WDAY_W-1:0] wd4_r;
  logic [36:0] prod365;

  // stage 5: day of year
  logic        era5_r;
  logic [8:0]  yoe5_r;
  logic [8:0]  doy5_r, doy_nxt;
  logic [WDAY_W-1:0] wd5_r;
  logic [1:0]  ycent;
  logic [17:0] ystart;
  logic [17:0] dsub;

  // stage 6: month from March
  logic        era6_r;
  logic [8:0]  yoe6_r;
  logic [8:0]  doy6_r;
  logic [3:0]  mp6_r, mp_nxt;
  logic [WDAY_W-1:0] wd6_r;
  logic [10:0] v153;
  logic [23:0] prod153;

  // stage 7: outputs
  logic [YEAR_W-1:0]  year7_r, year_nxt;
  logic [MONTH_W-1:0] month7_r, month_nxt;
  logic [DAY_W-1:0]   mday7_r, mday_nxt;
  logic [WDAY_W-1:0]  wd7_r;
  logic [8:0]         dday;

  always_comb begin
    era1_nxt = (days >= ERA5_START);
    doe1_nxt = era1_nxt ? ({2'd0, days} - {2'd0, ERA5_START})
                        : ({2'd0, days} + ERA4_BIAS);
    wx1_nxt  = days + 16'd4;
  end

  always_comb begin
    prod1460  = {18'd0, doe1_r} * {18'd0, RECIP_1460};
    q1460_nxt = prod1460[34:28];
    cent_nxt  = 3'(doe1_r >= CENT_DAYS) + 3'(doe1_r >= 18'd73048)
              + 3'(doe1_r >= 18'd109572) + 3'(doe1_r >= ERA_LAST_DAY);
    last_nxt  = (doe1_r == ERA_LAST_DAY);
    prod7     = {17'd0, wx1_r} * {16'd0, RECIP_7};
    q7_nxt    = prod7[32:19];
  end

  always_comb begin
    t_nxt  = doe2_r - {11'd0, q1460_2_r} + {15'd0, cent2_r} - {17'd0, last2_r};
    wsub   = wx2_r - ({2'd0, q7_2_r} * 16'd7);
    wd_nxt = wsub[WDAY_W-1:0];
  end

  always_comb begin
    prod365 = {19'd0, t3_r} * {18'd0, RECIP_365};
    yoe_nxt = prod365[35:27];
  end

  always_comb begin
    ycent   = 2'(yoe4_r >= 9'd100) + 2'(yoe4_r >= 9'd200) + 2'(yoe4_r >= 9'd300);
    ystart  = ({9'd0, yoe4_r} * 18'd365) + {11'd0, yoe4_r[8:2]} - {16'd0, ycent};
    dsub    = doe4_r - ystart;
    doy_nxt = dsub[8:0];
  end

  always_comb begin
    v153    = ({2'd0, doy5_r} * 11'd5) + 11'd2;
    prod153 = {13'd0, v153} * {11'd0, RECIP_153};
    mp_nxt  = prod153[23:20];
  end

  always_comb begin
    dday      = doy6_r - march_offset(mp6_r) + 9'd1;
    mday_nxt  = dday[DAY_W-1:0];
    month_nxt = (mp6_r < 4'd10) ? (mp6_r + 4'd2) : (mp6_r - 4'd10);
    year_nxt  = (era6_r ? ERA5_YEAR : ERA4_YEAR) + {3'd0, yoe6_r}
              + {11'd0, (mp6_r >= 4'd10)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      era1_r    <= era1_nxt;
      doe1_r    <= doe1_nxt;
      wx1_r     <= wx1_nxt;

      era2_r    <= era1_r;
      doe2_r    <= doe1_r;
      wx2_r     <= wx1_r;
      q1460_2_r <= q1460_nxt;
      cent2_r   <= cent_nxt;
      last2_r   <= last_nxt;
      q7_2_r    <= q7_nxt;

      era3_r    <= era2_r;
      doe3_r    <= doe2_r;
      t3_r      <= t_nxt;
      wd3_r     <= wd_nxt;

      era4_r    <= era3_r;
      doe4_r    <= doe3_r;
      yoe4_r    <= yoe_nxt;
      wd4_r     <= wd3_r;

      era5_r    <= era4_r;
      yoe5_r    <= yoe4_r;
      doy5_r    <= doy_nxt;
      wd5_r     <= wd4_r;

      era6_r    <= era5_r;
      yoe6_r    <= yoe5_r;
      doy6_r    <= doy5_r;
      mp6_r     <= mp_nxt;
      wd6_r     <= wd5_r;

      year7_r   <= year_nxt;
      month7_r  <= month_nxt;
      mday7_r   <= mday_nxt;
      wd7_r     <= wd6_r;
    end
  end

  assign year  = year7_r;
  assign month = month7_r;
  assign mday  = mday7_r;
  assign wday  = wd7_r;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import esc_pkg::*;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned LAST_YEAR     = 2106;
  localparam int unsigned DRAIN_CYCLES  = 30;     // pipeline is 9 deep, plenty of margin
  localparam int unsigned CYCLE_LIMIT   = 200000; // ~575 items, with wide margin for gaps and stalls
  localparam int          RANDOM_ITEMS  = 550;

  // One converted timestamp as it leaves the block.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   mday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [WDAY_W-1:0]  wday;
  } calendar_t;

  // Kinds of random timestamps: uniform, or aimed at a day, year, February/March or top-of-range boundary.
  typedef enum int {
    PICK_ANY,
    PICK_DAY_EDGE,
    PICK_YEAR_EDGE,
    PICK_MARCH_EDGE,
    PICK_TOP_END
  } pick_kind_e;

  // Month lengths of a common year and the weekday offsets per month.
  localparam int unsigned MONTH_DAYS[12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned WDAY_OFFSET[12]  = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  // Gregorian leap rule: every 4th year, except centuries not divisible by 400.
  function automatic bit is_leap_year(int unsigned y);
    if (y % 100 == 0) return (y % 400) == 0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned year_seconds(int unsigned y);
    return is_leap_year(y) ? 366 * SECS_PER_DAY : 365 * SECS_PER_DAY;
  endfunction

  // Seconds from the epoch to Jan 1 00:00:00 of year y.
  function automatic int unsigned year_start_secs(int unsigned y);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = EPOCH_YEAR; k < y; k++) acc += year_seconds(k);
    return acc;
  endfunction

  // Expected calendar date and time of day for one timestamp.
  function automatic calendar_t to_calendar(logic [SECS_W-1:0] secs);
    calendar_t   cal;
    int unsigned rest, yr, mon, month_len, mday, wyear, wd;
    bit          leap;
    rest = secs;
    yr   = EPOCH_YEAR;
    mon  = 0;
    // peel off whole years, then whole months of the year found
    while (rest >= year_seconds(yr)) begin
      rest -= year_seconds(yr);
      yr++;
    end
    leap = is_leap_year(yr);
    while (mon < 11) begin
      month_len = MONTH_DAYS[mon] + ((mon == 1 && leap) ? 1 : 0);
      if (rest < month_len * SECS_PER_DAY) break;
      rest -= month_len * SECS_PER_DAY;
      mon++;
    end
    mday = rest / SECS_PER_DAY + 1;
    rest = rest % SECS_PER_DAY;
    cal.hour   = HOUR_W'(rest / SECS_PER_HOUR);
    rest       = rest % SECS_PER_HOUR;
    cal.minute = MIN_W'(rest / 60);
    cal.second = SEC_W'(rest % 60);
    // January and February count with the previous year
    wyear = (mon < 2) ? yr - 1 : yr;
    wd = (wyear + wyear / 4 - wyear / 100 + wyear / 400 + WDAY_OFFSET[mon] + mday) % 7;
    cal.year  = YEAR_W'(yr);
    cal.month = MONTH_W'(mon);
    cal.mday  = DAY_W'(mday);
    cal.wday  = WDAY_W'(wd);
    return cal;
  endfunction

  // Holds the expected conversions in acceptance order and checks results.
  class calendar_scoreboard;
    calendar_t   pending_dates[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task note_input(logic [SECS_W-1:0] secs);
      pending_dates.push_back(to_calendar(secs));
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        report($sformatf("result %0d-%0d-%0d with nothing outstanding",
                         got.year, got.month, got.mday));
        return;
      end
      want = pending_dates.pop_front();
      check_field("year",    32'(got.year),   32'(want.year));
      check_field("month",   32'(got.month),  32'(want.month));
      check_field("day",     32'(got.mday),   32'(want.mday));
      check_field("hour",    32'(got.hour),   32'(want.hour));
      check_field("minute",  32'(got.minute), 32'(want.minute));
      check_field("second",  32'(got.second), 32'(want.second));
      check_field("weekday", 32'(got.wday),   32'(want.wday));
    endtask

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [SECS_W-1:0]  in_epoch_seconds;
  logic               out_valid;
  logic               out_stall;
  logic [YEAR_W-1:0]  out_year_value;
  logic [MONTH_W-1:0] out_month_index;
  logic [DAY_W-1:0]   out_day_of_month;
  logic [HOUR_W-1:0]  out_hour_value;
  logic [MIN_W-1:0]   out_minute_value;
  logic [SEC_W-1:0]   out_second_value;
  logic [WDAY_W-1:0]  out_weekday;

  calendar_scoreboard sb = new();
  calendar_t          seen_date;
  int unsigned        cycle_count;
  bit                 calm;       // set for the tail of the run: no idling anywhere
  int unsigned        in_gap_pct; // chance of an input gap, changes per stretch

  epoch_seconds_to_calendar dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_value   (out_year_value),
    .out_month_index  (out_month_index),
    .out_day_of_month (out_day_of_month),
    .out_hour_value   (out_hour_value),
    .out_minute_value (out_minute_value),
    .out_second_value (out_second_value),
    .out_weekday      (out_weekday)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Monitor: sampled at the rising edge, so both sides see settled values.
  // Result is checked before the input is noted; latency keeps them apart anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_date.year   = out_year_value;
        seen_date.month  = out_month_index;
        seen_date.mday   = out_day_of_month;
        seen_date.hour   = out_hour_value;
        seen_date.minute = out_minute_value;
        seen_date.second = out_second_value;
        seen_date.wday   = out_weekday;
        sb.check_result(seen_date);
      end
      if (in_valid && !in_stall) sb.note_input(in_epoch_seconds);
    end
  end

  // Result side back-pressure: random stall bursts, with
  // stretches of no stall at all; none once the run goes calm.
  initial begin
    int unsigned burst, stall_pct;
    out_stall = 1'b0;
    stall_pct = 10;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) stall_pct = $urandom_range(0, 2) * 15;
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one item at the falling edge and hold it until accepted.
  task automatic send_item(logic [SECS_W-1:0] secs);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid for a random burst; payload wiggles while nothing is offered.
  task automatic maybe_idle_input();
    int unsigned burst;
    if (calm || $urandom_range(0, 99) >= in_gap_pct) return;
    burst = $urandom_range(1, 15);
    @(negedge clk);
    in_valid         <= 1'b0;
    in_epoch_seconds <= $urandom;
    repeat (burst - 1) @(negedge clk);
  endtask

  // Random timestamp, biased toward day, year and February/March boundaries and the top of the range.
  function automatic logic [SECS_W-1:0] pick_secs();
    pick_kind_e  kind;
    int unsigned y, base;
    kind = pick_kind_e'($urandom_range(PICK_ANY, PICK_TOP_END));
    case (kind)
      PICK_DAY_EDGE: begin
        base = $urandom_range(0, 49709) * SECS_PER_DAY;
        return base + (($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                   : SECS_PER_DAY - 1 - $urandom_range(0, 2));
      end
      PICK_YEAR_EDGE: begin
        y = $urandom_range(EPOCH_YEAR + 1, LAST_YEAR);
        return year_start_secs(y) + $urandom_range(0, 2) - 1;
      end
      PICK_MARCH_EDGE: begin
        // last of February / first of March, leap and common years alike
        y = $urandom_range(EPOCH_YEAR, LAST_YEAR - 1);
        base = year_start_secs(y) + (59 + (is_leap_year(y) ? 1 : 0)) * SECS_PER_DAY;
        return base + $urandom_range(0, 2) - 1;
      end
      PICK_TOP_END: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [SECS_W-1:0] corner_secs[$];
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    calm             = 1'b0;
    in_gap_pct       = 20;

    // Edge cases: epoch, time-of-day rollovers, leap days (1972, 2000),
    // the 2100 non-leap century, the signed 32-bit rollover, the top of
    // the range and alternating bit patterns.
    corner_secs = {32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                   32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
                   32'd94694399, 32'd946684799, 32'd951782400, 32'd951868800,
                   32'd978307200, 32'd4107542399, 32'd4107542400,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'hFFFF_FFFE, 32'hFFFF_FFFF};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (corner_secs[i]) begin
      maybe_idle_input();
      send_item(corner_secs[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) in_gap_pct = $urandom_range(0, 2) * 20;
      if (n == RANDOM_ITEMS - 80) calm = 1'b1;
      maybe_idle_input();
      send_item(pick_secs());
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: everything accepted must come back, then let the pipe settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
